// ===== hw/rtl/rgi_pkg.sv =====
// Shared types, widths and constants of the radial gradient index core.
// Depends on nothing; every other RTL file imports it.
`default_nettype none
package rgi_pkg;

    localparam int RAMP_SIZE   = 2048;
    localparam int COORD_WIDTH = 24;
    localparam int IW   = $clog2(RAMP_SIZE);
    localparam int DW   = COORD_WIDTH + 1;
    localparam int PW   = 2 * DW;
    localparam int AW   = 2 * DW;
    localparam int BW   = 2 * DW + 1;
    localparam int SW   = 2 * DW + 2;
    localparam int ZW   = 2 * SW;
    localparam int QW   = SW + 1;
    localparam int NW   = AW + IW;
    localparam int HB   = 24;
    localparam int TW   = QW - 1 + HB;
    localparam int LOW  = (BW + 1) / 2;
    localparam int HIW  = BW - LOW;
    localparam int PPW  = 2 * LOW;
    localparam int MINT = 1000;

    typedef enum logic [1:0] {
        SPREAD_PAD     = 2'd0,
        SPREAD_REPEAT  = 2'd1,
        SPREAD_REFLECT = 2'd2,
        SPREAD_ALT_PAD = 2'd3
    } spread_t;

    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_FOCUS_X  = 3'd2;
    localparam logic [2:0] REG_FOCUS_Y  = 3'd3;
    localparam logic [2:0] REG_RADIUS   = 3'd4;
    localparam logic [2:0] REG_SPREAD   = 3'd5;

    typedef struct packed {
        spread_t mode;
        logic    nopix;
        logic    zero;
    } tag_t;

    typedef struct packed {
        tag_t          tag;
        logic [AW-1:0] a;
        logic [BW-1:0] b;
    } side_t;

    function automatic logic signed [DW-1:0] sx_coord(input logic [COORD_WIDTH-1:0] v);
        return signed'({v[COORD_WIDTH-1], v});
    endfunction

    function automatic logic signed [ZW-1:0] sx_part(input logic [PPW-1:0] v);
        return signed'({{(ZW-PPW){v[PPW-1]}}, v});
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rgi_front.sv =====
// Front pipeline: focus-relative vectors, quadratic terms A, b, C and the discriminant.
// Depends on rgi_pkg.
`default_nettype none
module rgi_front (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  en,
    input  wire logic                                  in_valid,
    input  wire logic [rgi_pkg::COORD_WIDTH-1:0]       pixel_x,
    input  wire logic [rgi_pkg::COORD_WIDTH-1:0]       pixel_y,
    input  wire logic [rgi_pkg::COORD_WIDTH-1:0]       center_x,
    input  wire logic [rgi_pkg::COORD_WIDTH-1:0]       center_y,
    input  wire logic [rgi_pkg::COORD_WIDTH-1:0]       focus_x,
    input  wire logic [rgi_pkg::COORD_WIDTH-1:0]       focus_y,
    input  wire logic [rgi_pkg::COORD_WIDTH-1:0]       radius,
    input  wire rgi_pkg::spread_t                      spread_mode,
    output logic                                       out_valid,
    output logic [rgi_pkg::ZW-1:0]                     disc,
    output rgi_pkg::side_t                             side
);
    import rgi_pkg::*;

    logic [5:0] vld_reg;

    logic signed [DW-1:0] dx_reg, dy_reg, rx_reg, ry_reg, rr_reg;
    tag_t                 tag1_reg, tag2_reg, tag3_reg;
    logic signed [PW-1:0] xx_reg, yy_reg, bx_reg, by_reg, rxx_reg, ryy_reg, rad2_reg;
    logic [AW-1:0]        a3_reg;
    logic signed [BW-1:0] b3_reg, c3_reg;
    side_t                side4_reg, side5_reg, side6_reg;
    logic [PPW-1:0]       bb_ll_reg, ac_ll_reg;
    logic signed [PPW-1:0] bb_hl_reg, bb_hh_reg, ac_hl_reg, ac_lh_reg, ac_hh_reg;
    logic signed [ZW-1:0] bb_reg, ac_reg, disc_reg;

    tag_t                 tag1_next;
    logic signed [DW-1:0] rad_s;
    logic [AW-1:0]        a3_next;
    logic signed [BW-1:0] b3_next, c3_next;
    logic [LOW-1:0]       b_lo, a_lo, c_lo;
    logic signed [HIW-1:0] b_hi, a_hi, c_hi;

    assign rad_s           = sx_coord(radius);
    assign tag1_next.mode  = spread_mode;
    assign tag1_next.nopix = (rad_s <= 0);
    assign tag1_next.zero  = (pixel_x == focus_x) && (pixel_y == focus_y);

    assign a3_next = AW'(xx_reg) + AW'(yy_reg);
    assign b3_next = signed'({bx_reg[PW-1], bx_reg}) + signed'({by_reg[PW-1], by_reg});
    assign c3_next = signed'({rxx_reg[PW-1], rxx_reg}) + signed'({ryy_reg[PW-1], ryy_reg})
                   - signed'({rad2_reg[PW-1], rad2_reg});

    assign b_lo = b3_reg[LOW-1:0];
    assign b_hi = b3_reg[BW-1:LOW];
    assign a_lo = a3_reg[LOW-1:0];
    assign a_hi = signed'(HIW'({1'b0, a3_reg} >> LOW));
    assign c_lo = c3_reg[LOW-1:0];
    assign c_hi = c3_reg[BW-1:LOW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg   <= sx_coord(pixel_x) - sx_coord(focus_x);
            dy_reg   <= sx_coord(pixel_y) - sx_coord(focus_y);
            rx_reg   <= sx_coord(focus_x) - sx_coord(center_x);
            ry_reg   <= sx_coord(focus_y) - sx_coord(center_y);
            rr_reg   <= rad_s;
            tag1_reg <= tag1_next;

            xx_reg   <= dx_reg * dx_reg;
            yy_reg   <= dy_reg * dy_reg;
            bx_reg   <= rx_reg * dx_reg;
            by_reg   <= ry_reg * dy_reg;
            rxx_reg  <= rx_reg * rx_reg;
            ryy_reg  <= ry_reg * ry_reg;
            rad2_reg <= rr_reg * rr_reg;
            tag2_reg <= tag1_reg;

            a3_reg   <= a3_next;
            b3_reg   <= b3_next;
            c3_reg   <= c3_next;
            tag3_reg <= tag2_reg;

            bb_ll_reg <= b_lo * b_lo;
            bb_hl_reg <= b_hi * signed'({1'b0, b_lo});
            bb_hh_reg <= b_hi * b_hi;
            ac_ll_reg <= a_lo * c_lo;
            ac_hl_reg <= a_hi * signed'({1'b0, c_lo});
            ac_lh_reg <= signed'({1'b0, a_lo}) * c_hi;
            ac_hh_reg <= a_hi * c_hi;
            side4_reg <= '{tag: tag3_reg, a: a3_reg, b: b3_reg};

            bb_reg <= (sx_part(bb_hh_reg) <<< (2 * LOW)) + (sx_part(bb_hl_reg) <<< (LOW + 1))
                    + signed'(ZW'(bb_ll_reg));
            ac_reg <= (sx_part(ac_hh_reg) <<< (2 * LOW))
                    + ((sx_part(ac_hl_reg) + sx_part(ac_lh_reg)) <<< LOW)
                    + signed'(ZW'(ac_ll_reg));
            side5_reg <= side4_reg;

            disc_reg  <= bb_reg - ac_reg;
            side6_reg <= side5_reg;
        end
    end

    assign out_valid = vld_reg[5];
    assign disc      = disc_reg;
    assign side      = side6_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/rgi_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, of the discriminant.
// Depends on rgi_pkg.
`default_nettype none
module rgi_sqrt (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic [rgi_pkg::ZW-1:0]    disc,
    input  wire rgi_pkg::side_t            side_in,
    output logic                           out_valid,
    output logic [rgi_pkg::SW-1:0]         root,
    output logic                           disc_neg,
    output rgi_pkg::side_t                 side_out
);
    import rgi_pkg::*;

    logic [ZW-1:0] rem_reg  [SW];
    logic [ZW-1:0] res_reg  [SW];
    side_t         side_reg [SW];
    logic [SW-1:0] neg_reg;
    logic [SW-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[SW-2:0], in_valid};
        end
    end

    for (genvar i = 0; i < SW; i++) begin : g_stage
        logic [ZW-1:0] rem_src, res_src, trial, rem_next, res_next;
        localparam logic [ZW-1:0] ONE = ZW'(1) << (2 * (SW - 1 - i));

        if (i == 0) begin : g_first
            assign rem_src = disc[ZW-1] ? '0 : disc;
            assign res_src = '0;
            always_ff @(posedge aclk) begin
                if (en) begin
                    side_reg[i] <= side_in;
                    neg_reg[i]  <= disc[ZW-1];
                end
            end
        end else begin : g_rest
            assign rem_src = rem_reg[i-1];
            assign res_src = res_reg[i-1];
            always_ff @(posedge aclk) begin
                if (en) begin
                    side_reg[i] <= side_reg[i-1];
                    neg_reg[i]  <= neg_reg[i-1];
                end
            end
        end

        assign trial = res_src + ONE;
        always_comb begin
            if (rem_src >= trial) begin
                rem_next = rem_src - trial;
                res_next = (res_src >> 1) + ONE;
            end else begin
                rem_next = rem_src;
                res_next = res_src >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= rem_next;
                res_reg[i] <= res_next;
            end
        end
    end

    assign out_valid = vld_reg[SW-1];
    assign root      = res_reg[SW-1][SW-1:0];
    assign disc_neg  = neg_reg[SW-1];
    assign side_out  = side_reg[SW-1];

endmodule
`default_nettype wire

// ===== hw/rtl/rgi_div.sv =====
// Ray parameter check, pipelined restoring division for the index, and spread.
// Depends on rgi_pkg; its last stage is the block's output register.
`default_nettype none
module rgi_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic [rgi_pkg::SW-1:0]    root,
    input  wire logic                      disc_neg,
    input  wire rgi_pkg::side_t            side,
    output logic                           out_valid,
    output logic [rgi_pkg::IW-1:0]         ramp_index,
    output logic                           no_pixel
);
    import rgi_pkg::*;

    localparam logic [HB-1:0] FULL = HB'(RAMP_SIZE - 1);

    logic signed [QW-1:0]      q;
    logic signed [QW+10-1:0]   q_scaled;
    logic                      t_small;

    logic [QW-2:0] qp_reg;
    logic [NW-1:0] num_reg;
    logic          sat_reg;
    tag_t          tag0_reg;
    logic          vld0_reg;

    logic [NW-1:0] rem_reg [HB];
    logic [HB-1:0] h_reg   [HB];
    logic [QW-2:0] qs_reg  [HB];
    logic [HB-1:0] sat_s_reg;
    tag_t          tag_reg [HB];
    logic [HB-1:0] vld_reg;

    logic [IW-1:0] idx_reg;
    logic          nopix_reg;
    logic          ovld_reg;

    assign q        = signed'(QW'(root)) - signed'({{(QW-BW){side.b[BW-1]}}, side.b});
    assign q_scaled = q * signed'(11'(MINT));
    assign t_small  = q_scaled < signed'((QW + 10)'(side.a));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld0_reg <= 1'b0;
            vld_reg  <= '0;
            ovld_reg <= 1'b0;
        end else if (en) begin
            vld0_reg <= in_valid;
            vld_reg  <= {vld_reg[HB-2:0], vld0_reg};
            ovld_reg <= vld_reg[HB-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qp_reg   <= q[QW-2:0];
            num_reg  <= (NW'(side.a) << IW) - NW'(side.a);
            sat_reg  <= disc_neg || t_small;
            tag0_reg <= side.tag;
        end
    end

    for (genvar j = 0; j < HB; j++) begin : g_bit
        localparam int K = HB - 1 - j;
        logic [NW-1:0] rem_src, rem_next;
        logic [HB-1:0] h_src, h_next;
        logic [QW-2:0] q_src;
        logic [TW-1:0] trial;

        if (j == 0) begin : g_first
            assign rem_src = num_reg;
            assign h_src   = '0;
            assign q_src   = qp_reg;
            always_ff @(posedge aclk) begin
                if (en) begin
                    sat_s_reg[j] <= sat_reg;
                    tag_reg[j]   <= tag0_reg;
                end
            end
        end else begin : g_rest
            assign rem_src = rem_reg[j-1];
            assign h_src   = h_reg[j-1];
            assign q_src   = qs_reg[j-1];
            always_ff @(posedge aclk) begin
                if (en) begin
                    sat_s_reg[j] <= sat_s_reg[j-1];
                    tag_reg[j]   <= tag_reg[j-1];
                end
            end
        end

        assign trial = TW'(q_src) << K;
        always_comb begin
            if (TW'(rem_src) >= trial) begin
                rem_next = rem_src - trial[NW-1:0];
                h_next   = h_src | (HB'(1) << K);
            end else begin
                rem_next = rem_src;
                h_next   = h_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= rem_next;
                h_reg[j]   <= h_next;
                qs_reg[j]  <= q_src;
            end
        end
    end

    logic [HB-1:0] h_fin;
    logic [IW-1:0] idx_next;
    tag_t          tag_fin;

    assign tag_fin = tag_reg[HB-1];

    always_comb begin
        if (tag_fin.zero) begin
            h_fin = '0;
        end else if (sat_s_reg[HB-1]) begin
            h_fin = FULL;
        end else begin
            h_fin = h_reg[HB-1];
        end
    end

    always_comb begin
        case (tag_fin.mode)
            SPREAD_REPEAT:  idx_next = h_fin[IW-1:0];
            SPREAD_REFLECT: idx_next = h_fin[IW] ? ~h_fin[IW-1:0] : h_fin[IW-1:0];
            default:        idx_next = (h_fin > FULL) ? FULL[IW-1:0] : h_fin[IW-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            idx_reg   <= tag_fin.nopix ? '0 : idx_next;
            nopix_reg <= tag_fin.nopix;
        end
    end

    assign out_valid  = ovld_reg;
    assign ramp_index = idx_reg;
    assign no_pixel   = nopix_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/radial_gradient_index_core.sv =====
// Top level of the focal radial gradient index core: configuration registers and streams.
// Depends on rgi_pkg, rgi_front, rgi_sqrt and rgi_div.
//
// Channel   Direction  Ports
// s_        in         s_tvalid, s_tready, s_tdata (pixel position)
// m_        out        m_tvalid, m_tready, m_tdata (ramp index), m_tuser (no_pixel)
// cfg_      in         cfg_valid, cfg_ready, cfg_index, cfg_data
//
// One transaction enters per cycle while the output is not stalled; the square root and
// divider stages compute one result bit each.
// Reset is synchronous; it clears the valid bits and the configuration registers, radius to 256.
// A stalled output holds the whole pipeline; nothing is lost or repeated.
`default_nettype none
module radial_gradient_index_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [23:0] pixel_x, [47:24] pixel_y
    input  wire logic [2*rgi_pkg::COORD_WIDTH-1:0]   s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [10:0] ramp_index, rest zero
    output logic [((rgi_pkg::IW+7)/8)*8-1:0]         m_tdata,
    // [0] no_pixel
    output logic                                     m_tuser,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [2:0]                          cfg_index,
    input  wire logic [rgi_pkg::COORD_WIDTH-1:0]     cfg_data
);
    import rgi_pkg::*;

    logic [COORD_WIDTH-1:0] cx_reg, cy_reg, fx_reg, fy_reg, rad_reg;
    spread_t                mode_reg;
    logic                   en;

    logic              f_valid, r_valid, r_neg;
    logic [ZW-1:0]     f_disc;
    side_t             f_side, r_side;
    logic [SW-1:0]     r_root;
    logic [IW-1:0]     idx;

    assign cfg_ready = 1'b1;
    assign en        = m_tready || !m_tvalid;
    assign s_tready  = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg   <= '0;
            cy_reg   <= '0;
            fx_reg   <= '0;
            fy_reg   <= '0;
            rad_reg  <= COORD_WIDTH'(256);
            mode_reg <= SPREAD_PAD;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CENTER_X: cx_reg   <= cfg_data;
                REG_CENTER_Y: cy_reg   <= cfg_data;
                REG_FOCUS_X:  fx_reg   <= cfg_data;
                REG_FOCUS_Y:  fy_reg   <= cfg_data;
                REG_RADIUS:   rad_reg  <= cfg_data;
                REG_SPREAD:   mode_reg <= spread_t'(cfg_data[1:0]);
                default:      ;
            endcase
        end
    end

    rgi_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_tvalid),
        .pixel_x     (s_tdata[COORD_WIDTH-1:0]),
        .pixel_y     (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .center_x    (cx_reg),
        .center_y    (cy_reg),
        .focus_x     (fx_reg),
        .focus_y     (fy_reg),
        .radius      (rad_reg),
        .spread_mode (mode_reg),
        .out_valid   (f_valid),
        .disc        (f_disc),
        .side        (f_side)
    );

    rgi_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .disc      (f_disc),
        .side_in   (f_side),
        .out_valid (r_valid),
        .root      (r_root),
        .disc_neg  (r_neg),
        .side_out  (r_side)
    );

    rgi_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (r_valid),
        .root       (r_root),
        .disc_neg   (r_neg),
        .side       (r_side),
        .out_valid  (m_tvalid),
        .ramp_index (idx),
        .no_pixel   (m_tuser)
    );

    assign m_tdata = (((IW + 7) / 8) * 8)'(idx);

endmodule
`default_nettype wire
